/* hw/rtl/lcdc_pkg.sv */
// Package with the LCD controller constants, register offsets and shared types.
`timescale 1ns / 1ps
`default_nettype none

package lcdc_pkg;

  localparam int unsigned DotW  = 9;
  localparam int unsigned LineW = 8;

  localparam logic [DotW:0]    DotsPerLine     = 10'd456;
  localparam logic [LineW-1:0] LastLine        = 8'd153;
  localparam logic [LineW-1:0] VisibleLines    = 8'd144;
  localparam logic [DotW-1:0]  HblankStartDot  = 9'd252;
  localparam logic [DotW-1:0]  XferStartDot    = 9'd80;
  localparam logic [7:0]       StatFixedBits   = 8'h80;

  typedef enum logic [1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActTick  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ModeHblank = 2'd0,
    ModeVblank = 2'd1,
    ModeOam    = 2'd2,
    ModeXfer   = 2'd3
  } mode_e;

  localparam logic [3:0] OffControl = 4'd0;
  localparam logic [3:0] OffStatus  = 4'd1;
  localparam logic [3:0] OffScrollY = 4'd2;
  localparam logic [3:0] OffScrollX = 4'd3;
  localparam logic [3:0] OffLine    = 4'd4;
  localparam logic [3:0] OffLineCmp = 4'd5;
  localparam logic [3:0] OffBgPal   = 4'd7;
  localparam logic [3:0] OffObjPal0 = 4'd8;
  localparam logic [3:0] OffObjPal1 = 4'd9;
  localparam logic [3:0] OffWinY    = 4'd10;
  localparam logic [3:0] OffWinX    = 4'd11;

  // Stat enable bit positions.
  localparam int unsigned EnHblank = 0;
  localparam int unsigned EnVblank = 1;
  localparam int unsigned EnOam    = 2;
  localparam int unsigned EnMatch  = 3;

  typedef struct packed {
    logic [DotW-1:0]  dot;
    logic [LineW-1:0] line;
    mode_e            mode;
    logic             stat;
    logic             vblank;
  } timing_t;

endpackage

`default_nettype wire

/* hw/rtl/lcdc_timing.sv */
// Next dot, line and mode after a tick, with the interrupt requests it raises.
`timescale 1ns / 1ps
`default_nettype none

module lcdc_timing (
  input  wire logic [lcdc_pkg::DotW-1:0]  dot_i,
  input  wire logic [lcdc_pkg::LineW-1:0] line_i,
  input  wire lcdc_pkg::mode_e            mode_i,
  input  wire logic [3:0]                 stat_en_i,
  input  wire logic [7:0]                 line_cmp_i,
  input  wire logic [5:0]                 tick_dots_i,
  output lcdc_pkg::timing_t               next_o
);
  import lcdc_pkg::*;

  logic [DotW:0]    sum;
  logic             wrap;
  logic [DotW:0]    dot_wr;
  logic [LineW-1:0] line_n;
  mode_e            mode_n;
  logic             enter_irq;

  always_comb begin
    sum    = {1'b0, dot_i} + {{(DotW - 5){1'b0}}, tick_dots_i};
    wrap   = (sum >= DotsPerLine);
    dot_wr = wrap ? (sum - DotsPerLine) : sum;
    if (wrap) begin
      line_n = (line_i == LastLine) ? '0 : line_i + 8'd1;
    end else begin
      line_n = line_i;
    end

    if (line_n >= VisibleLines) begin
      mode_n = ModeVblank;
    end else if (dot_wr[DotW-1:0] >= HblankStartDot) begin
      mode_n = ModeHblank;
    end else if (dot_wr[DotW-1:0] >= XferStartDot) begin
      mode_n = ModeXfer;
    end else begin
      mode_n = ModeOam;
    end

    enter_irq = 1'b0;
    next_o.vblank = 1'b0;
    if (mode_n != mode_i) begin
      case (mode_n)
        ModeOam:    enter_irq = stat_en_i[EnOam];
        ModeHblank: enter_irq = stat_en_i[EnHblank];
        ModeVblank: begin
          enter_irq     = stat_en_i[EnVblank];
          next_o.vblank = 1'b1;
        end
        default:    enter_irq = 1'b0;
      endcase
    end

    next_o.dot  = dot_wr[DotW-1:0];
    next_o.line = line_n;
    next_o.mode = mode_n;
    next_o.stat = enter_irq || ((line_n == line_cmp_i) && stat_en_i[EnMatch]);
  end

endmodule

`default_nettype wire

/* hw/rtl/lcd_controller_regs_and_timing.sv */
// Top level of the LCD controller register file and line/dot timing.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid_i, in_stall_o | action, reg_offset, write_value, tick_dots
//   out     | output    | out_valid_o, out_stall_i | read_data, stat_irq, vblank_irq
//
// Each transaction is decoded and applied to the registers in the cycle it is
// accepted; its result appears in the output register in the following cycle.
// One transaction per cycle, unless stalled; the only loop is the dot/line update.
// The input stalls only while a result is held in the output register and the
// output side stalls. Reset clears all registers and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module lcd_controller_regs_and_timing (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [3:0] reg_offset_i,
  input  wire logic [7:0] write_value_i,
  input  wire logic [5:0] tick_dots_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            stat_irq_o,
  output logic            vblank_irq_o
);
  import lcdc_pkg::*;

  logic [7:0]       control_q, scroll_y_q, scroll_x_q, line_cmp_q;
  logic [7:0]       win_y_q, win_x_q, bg_pal_q;
  logic [5:0]       obj_pal0_q, obj_pal1_q;
  logic [3:0]       stat_en_q;
  logic [DotW-1:0]  dot_q;
  logic [LineW-1:0] line_q;
  mode_e            mode_q;

  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic       stat_q, vblank_q;

  logic       accept;
  logic       do_tick;
  logic [7:0] rd_data;
  timing_t    next;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign do_tick    = accept && (action_i == ActTick) && control_q[7];

  lcdc_timing u_timing (
    .dot_i       (dot_q),
    .line_i      (line_q),
    .mode_i      (mode_q),
    .stat_en_i   (stat_en_q),
    .line_cmp_i  (line_cmp_q),
    .tick_dots_i (tick_dots_i),
    .next_o      (next)
  );

  always_comb begin
    unique case (reg_offset_i)
      OffControl: rd_data = control_q;
      OffStatus:  rd_data = StatFixedBits | {1'b0, stat_en_q, (line_cmp_q == line_q), mode_q};
      OffScrollY: rd_data = scroll_y_q;
      OffScrollX: rd_data = scroll_x_q;
      OffLine:    rd_data = line_q;
      OffLineCmp: rd_data = line_cmp_q;
      OffBgPal:   rd_data = bg_pal_q;
      OffObjPal0: rd_data = {obj_pal0_q, 2'b11};
      OffObjPal1: rd_data = {obj_pal1_q, 2'b11};
      OffWinY:    rd_data = win_y_q;
      OffWinX:    rd_data = win_x_q;
      default:    rd_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q  <= '0;
      stat_en_q  <= '0;
      scroll_y_q <= '0;
      scroll_x_q <= '0;
      line_cmp_q <= '0;
      win_y_q    <= '0;
      win_x_q    <= '0;
      bg_pal_q   <= '0;
      obj_pal0_q <= '0;
      obj_pal1_q <= '0;
      dot_q      <= '0;
      line_q     <= '0;
      mode_q     <= ModeHblank;
    end else begin
      if (accept && (action_i == ActWrite)) begin
        unique case (reg_offset_i)
          OffControl: control_q  <= write_value_i;
          OffStatus:  stat_en_q  <= write_value_i[6:3];
          OffScrollY: scroll_y_q <= write_value_i;
          OffScrollX: scroll_x_q <= write_value_i;
          OffLineCmp: line_cmp_q <= write_value_i;
          OffBgPal:   bg_pal_q   <= write_value_i;
          OffObjPal0: obj_pal0_q <= write_value_i[7:2];
          OffObjPal1: obj_pal1_q <= write_value_i[7:2];
          OffWinY:    win_y_q    <= write_value_i;
          OffWinX:    win_x_q    <= write_value_i;
          default: ;
        endcase
      end
      if (do_tick) begin
        dot_q  <= next.dot;
        line_q <= next.line;
        mode_q <= next.mode;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_data_q <= '0;
      stat_q      <= 1'b0;
      vblank_q    <= 1'b0;
    end else if (accept) begin
      read_data_q <= (action_i == ActRead) ? rd_data : 8'h00;
      stat_q      <= do_tick && next.stat;
      vblank_q    <= do_tick && next.vblank;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign stat_irq_o   = stat_q;
  assign vblank_irq_o = vblank_q;

endmodule

`default_nettype wire
